// ===== hw/rtl/soc_pkg.sv =====
// Shared types for the sorted occurrence counter.
// Holds the command and status bundles exchanged by soc_ctrl and soc_dp.
// No dependencies.
package soc_pkg;

  // Field widths of the result beat and of the input value.
  localparam int unsigned OCC_W   = 9;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned VALUE_W = 32;

  // Input action codes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // append the input beat to the table
    logic query_init;  // latch the query and open the lower-bound range
    logic rd;          // read the table at the midpoint of the open range
    logic cmp_lower;   // narrow the range with the lower-bound test
    logic cmp_upper;   // narrow the range with the upper-bound test
    logic ub_init;     // keep the first match and reopen the whole range
    logic finish;      // form the result and update the running total
  } soc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_open;  // the search range still holds entries
    logic lb_hit;      // the lower-bound entry equals the queried value
  } soc_sts_t;

endpackage

// ===== hw/rtl/sorted_occurrence_counter.sv =====
// Sorted occurrence counter, top level.
// Instantiates soc_ctrl and soc_dp; depends on soc_pkg.
//
// Usage: a beat is taken when start is high and busy is low. A load beat
// (in_action = 0) appends in_value to the table in that same cycle, after
// emptying it when in_start_new_table is set; loads past DEPTH entries are
// dropped. Loads give no result and busy stays low, so loads may come back
// to back, one per cycle.
// A query beat (in_action = 1) runs a lower-bound binary search over the
// loaded entries and, on a match, an upper-bound search. Each search step
// reads the table memory in the read state and compares in the compare
// state, and each search ends in its read state when it sees its range
// closed; a search has at most ceil(log2(len + 1)) steps, len being the
// fill count. Its result beat shows on out_* with out_valid high for one
// cycle, during which busy is already low and a new beat may enter.
// The single table read port sets how long a query takes.
// The receiver cannot stall: each result stands for exactly one cycle.
// Reset (rst_n low, synchronous) empties the table, clears the running
// total and returns the block to idle; the table memory is not cleared.
module sorted_occurrence_counter #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_action,
  input  logic                               in_start_new_table,
  input  logic                               in_clear_total,
  input  logic signed [soc_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  output logic [soc_pkg::OCC_W-1:0]          out_occurrences,
  output logic [soc_pkg::POS_W-1:0]          out_first_position,
  output logic                               out_found,
  output logic [31:0]                        out_running_total
);

  soc_pkg::soc_cmd_t cmd;
  soc_pkg::soc_sts_t sts;

  // Sequencer.
  soc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Table, search bounds and result registers.
  soc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_start_new_table (in_start_new_table),
    .in_clear_total     (in_clear_total),
    .in_value           (in_value),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_occurrences    (out_occurrences),
    .out_first_position (out_first_position),
    .out_found          (out_found),
    .out_running_total  (out_running_total)
  );

`ifndef NO_ASSERTIONS
  // A result beat is shown only once the sequencer is back in idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // A query keeps the block busy in the following cycle.
  a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == soc_pkg::ACT_QUERY) |=> busy)
    else $error("query did not start a search");

  // Two result beats never come in adjacent cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Without a match the first position reads as zero.
  a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_first_position == '0))
    else $error("nonzero position on a miss");
`endif

endmodule

// ===== hw/rtl/soc_ctrl.sv =====
// Controller state machine of the sorted occurrence counter.
// Sequences loads, the two binary searches and the result beat.
// Depends on soc_pkg.
module soc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_action,
  input  soc_pkg::soc_sts_t sts,
  output soc_pkg::soc_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LB_RD  = 6'b000010,
    S_LB_CMP = 6'b000100,
    S_UB_RD  = 6'b001000,
    S_UB_CMP = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_action == soc_pkg::ACT_QUERY) begin
            cmd.query_init = 1'b1;
            state_nxt      = S_LB_RD;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_LB_RD: begin
        if (sts.range_open) begin
          cmd.rd    = 1'b1;
          state_nxt = S_LB_CMP;
        end else if (sts.lb_hit) begin
          cmd.ub_init = 1'b1;
          state_nxt   = S_UB_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LB_CMP: begin
        cmd.cmp_lower = 1'b1;
        state_nxt     = S_LB_RD;
      end
      S_UB_RD: begin
        if (sts.range_open) begin
          cmd.rd    = 1'b1;
          state_nxt = S_UB_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UB_CMP: begin
        cmd.cmp_upper = 1'b1;
        state_nxt     = S_UB_RD;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The block takes a new beat only in the idle state.
  assign busy = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/soc_dp.sv =====
// Datapath of the sorted occurrence counter: table memory, search bounds,
// running total and the result registers. Depends on soc_pkg.
module soc_dp #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  soc_pkg::soc_cmd_t                 cmd,
  input  logic                              in_start_new_table,
  input  logic                              in_clear_total,
  input  logic signed [soc_pkg::VALUE_W-1:0] in_value,
  output soc_pkg::soc_sts_t                 sts,
  output logic                              out_valid,
  output logic [soc_pkg::OCC_W-1:0]         out_occurrences,
  output logic [soc_pkg::POS_W-1:0]         out_first_position,
  output logic                              out_found,
  output logic [31:0]                       out_running_total
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);

  // Table memory; entries at or above the fill count are never read.
  logic signed [soc_pkg::VALUE_W-1:0] mem [DEPTH];

  logic [LW-1:0]                      len_r, len_nxt;
  logic [31:0]                        total_r, total_nxt;
  logic signed [soc_pkg::VALUE_W-1:0] value_r;
  logic [LW-1:0]                      lo_r, lo_nxt;
  logic [LW-1:0]                      hp1_r, hp1_nxt;   // one past the range end
  logic [LW-1:0]                      mid_r;
  logic [LW-1:0]                      first_r;
  logic                               eq_r, eq_nxt;
  logic                               hit_r, hit_nxt;
  logic signed [soc_pkg::VALUE_W-1:0] rd_data_r;
  logic                               out_valid_r;
  logic [soc_pkg::OCC_W-1:0]          occ_r;
  logic [soc_pkg::POS_W-1:0]          pos_r;
  logic                               found_r;

  logic [LW:0]    mid_sum;
  logic [LW-1:0]  mid;
  logic [LW-1:0]  mid_inc;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [LW-1:0]  count;
  logic [32:0]    count_ext;
  logic [31:0]    first_ext;
  logic [32:0]    total_sum;
  logic [31:0]    base_total;

  // Midpoint of the open range, rounded down.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hp1_r} - {{LW{1'b0}}, 1'b1};
  assign mid     = mid_sum[LW:1];
  assign mid_inc = mid_r + {{(LW-1){1'b0}}, 1'b1};

  // Status toward the controller.
  assign sts.range_open = (lo_r < hp1_r);
  assign sts.lb_hit     = (lo_r < len_r) && eq_r;

  // Append address and acceptance of a load.
  assign wr_en   = cmd.load && (in_start_new_table || (len_r < LW'(DEPTH)));
  assign wr_addr = in_start_new_table ? '0 : len_r[AW-1:0];

  // Table memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[mid[AW-1:0]];
    end
  end

  // Number of equal entries between the two bounds.
  always_comb begin
    if (hit_r && (hp1_r > first_r)) begin
      count = hp1_r - first_r;
    end else begin
      count = '0;
    end
  end
  assign count_ext  = 33'(count);
  assign first_ext  = (count != '0) ? 32'(first_r) : 32'd0;
  assign base_total = total_r;
  assign total_sum  = {1'b0, base_total} + count_ext;

  // Next values of the search and table state.
  always_comb begin
    len_nxt   = len_r;
    total_nxt = total_r;
    lo_nxt    = lo_r;
    hp1_nxt   = hp1_r;
    eq_nxt    = eq_r;
    hit_nxt   = hit_r;

    if (wr_en) begin
      len_nxt = in_start_new_table ? LW'(1) : (len_r + {{(LW-1){1'b0}}, 1'b1});
    end

    if (cmd.query_init) begin
      lo_nxt  = '0;
      hp1_nxt = len_r;
      eq_nxt  = 1'b0;
      hit_nxt = 1'b0;
      if (in_clear_total) begin
        total_nxt = '0;
      end
    end

    // Lower bound: move past entries below the value.
    if (cmd.cmp_lower) begin
      if (rd_data_r < value_r) begin
        lo_nxt = mid_inc;
      end else begin
        hp1_nxt = mid_r;
        eq_nxt  = (rd_data_r == value_r);
      end
    end

    // Upper bound: move past entries not above the value.
    if (cmd.cmp_upper) begin
      if (rd_data_r <= value_r) begin
        lo_nxt = mid_inc;
      end else begin
        hp1_nxt = mid_r;
      end
    end

    if (cmd.ub_init) begin
      lo_nxt  = '0;
      hp1_nxt = len_r;
      hit_nxt = 1'b1;
    end

    // Saturating accumulation of the count.
    if (cmd.finish) begin
      total_nxt = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      total_r     <= total_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  // Search registers and result payload.
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hp1_r <= hp1_nxt;
    eq_r  <= eq_nxt;
    hit_r <= hit_nxt;
    if (cmd.query_init) begin
      value_r <= in_value;
    end
    if (cmd.rd) begin
      mid_r <= mid;
    end
    if (cmd.ub_init) begin
      first_r <= lo_r;
    end
    if (cmd.finish) begin
      occ_r   <= count_ext[soc_pkg::OCC_W-1:0];
      pos_r   <= first_ext[soc_pkg::POS_W-1:0];
      found_r <= (count != '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_occurrences    = occ_r;
  assign out_first_position = pos_r;
  assign out_found          = found_r;
  assign out_running_total  = total_r;

endmodule

// ===== bench/tb_sorted_occurrence_counter.sv =====
`timescale 1ns / 1ps
// Testbench for sorted_occurrence_counter: loads tables, queries them and checks each result
// against a predictor of the table, the two binary searches and the saturating total.
// Depends on soc_pkg and the sorted_occurrence_counter RTL.
module tb_sorted_occurrence_counter;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned RANDOM_ITEMS = 600;

  typedef struct packed {
    logic [soc_pkg::OCC_W-1:0] occ;
    logic [soc_pkg::POS_W-1:0] pos;
    logic                      found;
    logic [31:0]               total;
  } count_result_t;

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic                               in_action = soc_pkg::ACT_LOAD;
  logic                               in_start_new_table = 1'b0;
  logic                               in_clear_total = 1'b0;
  logic signed [soc_pkg::VALUE_W-1:0] in_value = '0;
  logic                               out_valid;
  logic [soc_pkg::OCC_W-1:0]          out_occurrences;
  logic [soc_pkg::POS_W-1:0]          out_first_position;
  logic                               out_found;
  logic [31:0]                        out_running_total;

  // Predictor state: the loaded table, its fill count and the running total.
  logic signed [soc_pkg::VALUE_W-1:0] model_table [DEPTH];
  int                                 model_len;
  logic [31:0]                        model_total;

  count_result_t pending_counts [$];
  int            failures = 0;
  bit            idle_enable = 1'b1;

  sorted_occurrence_counter #(.DEPTH(DEPTH)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_start_new_table (in_start_new_table),
    .in_clear_total     (in_clear_total),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_occurrences    (out_occurrences),
    .out_first_position (out_first_position),
    .out_found          (out_found),
    .out_running_total  (out_running_total)
  );

  // Free-running clock, 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog for a hung block.
  initial begin
    #(12 * 2_000_000);
    $display("Verification failed");
    $finish;
  end

  // Update the predictor with one accepted beat; a query queues its expected result.
  task automatic apply_beat(input logic act, input logic fresh, input logic clr,
                            input logic signed [soc_pkg::VALUE_W-1:0] val);
    int            lo;
    int            hi;
    int            mid;
    int            first_idx;
    int unsigned   count;
    logic [32:0]   sum;
    count_result_t res;
    if (act == soc_pkg::ACT_LOAD) begin
      if (fresh) model_len = 0;
      if (model_len < DEPTH) begin
        model_table[model_len] = val;
        model_len++;
      end
    end else begin
      if (clr) model_total = '0;
      count = 0;
      first_idx = 0;
      // Lower bound: first entry not below the value.
      lo = 0;
      hi = model_len - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (model_table[mid] < val) lo = mid + 1;
        else hi = mid - 1;
      end
      if (lo < model_len && model_table[lo] == val) begin
        first_idx = lo;
        // Upper bound: hi ends on the last entry not above the value.
        lo = 0;
        hi = model_len - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (model_table[mid] <= val) lo = mid + 1;
          else hi = mid - 1;
        end
        if (hi >= first_idx) count = hi - first_idx + 1;
        else first_idx = 0;
      end
      sum = {1'b0, model_total} + count;
      model_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      res.occ   = count[soc_pkg::OCC_W-1:0];
      res.pos   = first_idx[soc_pkg::POS_W-1:0];
      res.found = (count != 0);
      res.total = model_total;
      pending_counts.insert(pending_counts.size(), res);
    end
  endtask

  // Present one beat, with a random gap first if enabled, and hold it until the block takes it.
  task automatic send_beat(input logic act, input logic fresh, input logic clr,
                           input logic signed [soc_pkg::VALUE_W-1:0] val);
    while (idle_enable && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_action          <= act;
    in_start_new_table <= fresh;
    in_clear_total     <= clr;
    in_value           <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_beat(act, fresh, clr, val);
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    count_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_counts.size() == 0) begin
        $error("result beat with no query outstanding");
        failures++;
      end else begin
        exp_res = pending_counts.pop_front();
        if (out_occurrences !== exp_res.occ) begin
          $error("occurrences: expected %0d, actual %0d", exp_res.occ, out_occurrences);
          failures++;
        end
        if (out_first_position !== exp_res.pos) begin
          $error("first_position: expected %0d, actual %0d", exp_res.pos, out_first_position);
          failures++;
        end
        if (out_found !== exp_res.found) begin
          $error("found: expected %0d, actual %0d", exp_res.found, out_found);
          failures++;
        end
        if (out_running_total !== exp_res.total) begin
          $error("running_total: expected %0d, actual %0d", exp_res.total, out_running_total);
          failures++;
        end
      end
    end
  end

  // Draw a value from one of several ranges: narrow, medium, full width or the extremes.
  function automatic logic signed [soc_pkg::VALUE_W-1:0] pick_value(input int mode);
    logic signed [soc_pkg::VALUE_W-1:0] edges [7];
    edges = '{32'sh8000_0000, 32'sh8000_0001, -32'sd1, 32'sd0, 32'sd1,
              32'sh7FFF_FFFE, 32'sh7FFF_FFFF};
    case (mode)
      0:       return $urandom_range(0, 8) - 4;
      1:       return $urandom_range(0, 2000) - 1000;
      2:       return $urandom;
      default: return edges[$urandom_range(0, 6)];
    endcase
  endfunction

  // A query on the empty table after reset; the table flag is ignored on a query.
  task automatic test_empty_table();
    send_beat(soc_pkg::ACT_QUERY, 1'b1, 1'b1, 32'sd0);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, 32'sh8000_0000);
  endtask

  // A sorted table with duplicates and both extremes of the value range.
  task automatic test_sorted_lookup();
    logic signed [soc_pkg::VALUE_W-1:0] vals [8];
    vals = '{32'sh8000_0000, -32'sd5, -32'sd5, 32'sd0, 32'sd7, 32'sd7, 32'sd7,
             32'sh7FFF_FFFF};
    foreach (vals[i]) send_beat(soc_pkg::ACT_LOAD, i == 0, i == 3, vals[i]);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, 32'sh8000_0000);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, 32'sh7FFF_FFFF);
    send_beat(soc_pkg::ACT_QUERY, 1'b1, 1'b0, -32'sd5);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b1, 32'sd7);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, 32'sd0);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, 32'sd3);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, 32'sh7FFF_FFFE);
  endtask

  // Fill the table to its depth, drop a load past it, then restart it with a fresh load.
  task automatic test_full_table();
    for (int i = 0; i < DEPTH; i++) send_beat(soc_pkg::ACT_LOAD, i == 0, 1'b0, 32'sd42);
    send_beat(soc_pkg::ACT_LOAD, 1'b0, 1'b0, 32'sd43);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b1, 32'sd42);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, 32'sd43);
    send_beat(soc_pkg::ACT_LOAD, 1'b1, 1'b0, 32'sd5);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, 32'sd5);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, 32'sd42);
    // Distinct ascending entries so a match lands on the last position.
    for (int i = 0; i < DEPTH; i++) send_beat(soc_pkg::ACT_LOAD, i == 0, 1'b0, i * 3 - 300);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, (DEPTH - 1) * 3 - 300);
    send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, -32'sd300);
  endtask

  // An unsorted table: the searches still run as if it were sorted.
  task automatic test_unsorted_table();
    logic signed [soc_pkg::VALUE_W-1:0] vals [6];
    vals = '{32'sd9, 32'sd3, 32'sd9, 32'sd1, 32'sd9, 32'sd2};
    foreach (vals[i]) send_beat(soc_pkg::ACT_LOAD, i == 0, 1'b0, vals[i]);
    foreach (vals[i]) send_beat(soc_pkg::ACT_QUERY, 1'b0, 1'b0, vals[i]);
  endtask

  // Random tables, mostly sorted and small, each followed by a run of queries.
  task automatic test_random_tables();
    int random_items;
    int size;
    int mode;
    int n_queries;
    int vals [$];
    bit keep_table;
    bit scramble;
    logic signed [soc_pkg::VALUE_W-1:0] qval;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      // A stretch in the middle of the run with no gaps at all.
      idle_enable = !(random_items >= 200 && random_items < 400);
      case ($urandom_range(0, 99)) inside
        [0:89]:  size = $urandom_range(1, 20);
        [90:97]: size = $urandom_range(21, 100);
        default: size = $urandom_range(200, 260);
      endcase
      mode = $urandom_range(0, 3);
      keep_table = ($urandom_range(0, 99) < 5);
      scramble = ($urandom_range(0, 99) < 15);
      vals.delete();
      for (int i = 0; i < size; i++) vals.insert(vals.size(), pick_value(mode));
      if (!scramble) vals.sort();
      foreach (vals[i]) begin
        send_beat(soc_pkg::ACT_LOAD, (i == 0) && !keep_table, 1'($urandom_range(0, 1)),
                  vals[i]);
        random_items++;
      end
      n_queries = $urandom_range(2, 12);
      for (int q = 0; q < n_queries; q++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: qval = vals[$urandom_range(0, vals.size() - 1)];
          7:                   qval = vals[$urandom_range(0, vals.size() - 1)] + 1;
          default:             qval = pick_value(mode);
        endcase
        send_beat(soc_pkg::ACT_QUERY, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                  qval);
        random_items++;
      end
    end
    idle_enable = 1'b1;
  endtask

  // Reset, the tests in turn, then drain the outstanding results.
  initial begin
    int drain;
    model_len = 0;
    model_total = '0;
    foreach (model_table[i]) model_table[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_sorted_lookup();
    test_full_table();
    test_unsorted_table();
    test_random_tables();

    start <= 1'b0;
    drain = 0;
    while (pending_counts.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (50) @(posedge clk);
    if (pending_counts.size() != 0) begin
      $error("%0d query results never arrived", pending_counts.size());
      failures++;
    end

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/soc_pkg.sv
hw/rtl/soc_ctrl.sv
hw/rtl/soc_dp.sv
hw/rtl/sorted_occurrence_counter.sv
bench/tb_sorted_occurrence_counter.sv
